// File: hdl/sik_pkg.sv
// Shared types, constants and elaboration-time table builders for the arm solver.
`timescale 1ns / 1ps
`default_nettype none
package sik_pkg;

  // Configuration register indexes.
  localparam logic REG_INNER = 1'b0;
  localparam logic REG_OUTER = 1'b1;

  localparam int LINK_WIDTH = 31;
  localparam int CORDIC_STEPS = 57;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CLAMPED = 2'd1,
    ST_ORIGIN  = 2'd2
  } reach_t;

  // Normalization bound for the vectoring input magnitude.
  localparam logic [63:0] NORM_HIGH = 64'h0800_0000_0000_0000;
  // One in the Q.120 square of a Q.60 ratio.
  localparam logic [127:0] ONE_Q120 = 128'd1 << 120;
  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  // Shift-subtract division, used only to build constants at elaboration.
  function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Gregory series for atan(1/n) in Q.62, truncated term by term.
  function automatic logic [63:0] atan_series(input logic [63:0] n);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] d;
    sum = '0;
    term = const_udiv(64'd1 << 62, n);
    for (int k = 0; k < 40; k++) begin
      d = const_udiv(term, 64'(2 * k + 1));
      if (k % 2 == 1) sum = sum - d;
      else sum = sum + d;
      term = const_udiv(const_udiv(term, n), n);
    end
    return sum;
  endfunction

  function automatic logic [63:0] pi_q62();
    return (atan_series(64'd5) << 4) - (atan_series(64'd239) << 2);
  endfunction

  function automatic logic [63:0] atan_entry(input int idx);
    if (idx == 0) return ((pi_q62() >> 2) + 64'd32) >> 6;
    return (atan_series(64'd1 << idx) + 64'd32) >> 6;
  endfunction

  localparam logic [63:0] PI_Q = (pi_q62() + 64'd32) >> 6;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sik_ifs.sv
// Valid/ready channels for target positions and joint angle results.
`timescale 1ns / 1ps
`default_nettype none
interface sik_target_if #(parameter int COORD_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [COORD_WIDTH-1:0] x_pos;
  logic signed [COORD_WIDTH-1:0] y_pos;
  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink (input valid, input x_pos, input y_pos, output ready);
endinterface

interface sik_joint_if #(parameter int ANGLE_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [ANGLE_WIDTH-1:0] shoulder_angle;
  logic [ANGLE_WIDTH-3:0] elbow_angle;
  logic [1:0] reach_status;
  modport source (output valid, output shoulder_angle, output elbow_angle,
                  output reach_status, input ready);
  modport sink (input valid, input shoulder_angle, input elbow_angle,
                input reach_status, output ready);
endinterface
`default_nettype wire

// File: hdl/sik_delay.sv
// Enable-gated shift line that keeps side data aligned with the datapath.
`timescale 1ns / 1ps
`default_nettype none
module sik_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);
  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) taps[i] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];
endmodule
`default_nettype wire

// File: hdl/sik_mul.sv
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
`timescale 1ns / 1ps
`default_nettype none
module sik_mul (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [63:0]  a,
  input  wire logic [63:0]  b,
  output logic      [127:0] p
);
  logic [63:0] p00, p01, p10, p11;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= a[31:0] * b[31:0];
      p01 <= a[31:0] * b[63:32];
      p10 <= a[63:32] * b[31:0];
      p11 <= a[63:32] * b[63:32];
      p   <= {64'd0, p00} + {32'd0, p01, 32'd0} + {32'd0, p10, 32'd0} + {p11, 64'd0};
    end
  end
endmodule
`default_nettype wire

// File: hdl/sik_isqrt.sv
// Integer square root as a row of 64 cells, one result bit per cell.
`timescale 1ns / 1ps
`default_nettype none
module sik_isqrt (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [127:0] n,
  output logic      [63:0]  root
);
  logic [127:0] rem_s  [65];
  logic [63:0]  root_s [65];

  assign rem_s[0]  = n;
  assign root_s[0] = '0;

  for (genvar k = 0; k < 64; k++) begin : g_cell
    localparam int BIT = 63 - k;
    logic [127:0] trial;
    assign trial = ({64'd0, root_s[k]} << (BIT + 1)) + (128'd1 << (2 * BIT));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_s[k] >= trial) begin
          rem_s[k+1]  <= rem_s[k] - trial;
          root_s[k+1] <= root_s[k] | (64'd1 << BIT);
        end else begin
          rem_s[k+1]  <= rem_s[k];
          root_s[k+1] <= root_s[k];
        end
      end
    end
  end

  assign root = root_s[64];
endmodule
`default_nettype wire

// File: hdl/sik_divide.sv
// Signed Q.60 ratio (p - q) / d, clamped to +-1, as a row of restoring cells.
`timescale 1ns / 1ps
`default_nettype none
module sik_divide (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [127:0] p,
  input  wire logic [127:0] q,
  input  wire logic [127:0] d,
  output logic      [63:0]  ratio,
  output logic              clamped
);
  import sik_pkg::*;

  logic [128:0] diff;
  logic [127:0] rem_s [62];
  logic [63:0]  quo_s [62];
  logic [127:0] den_s [62];
  logic         neg_s [62];
  logic         clp_s [62];

  assign diff = {1'b0, p} - {1'b0, q};

  // Setup: magnitude and sign of the numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[0] <= diff[128];
      rem_s[0] <= diff[128] ? (128'd0 - diff[127:0]) : diff[127:0];
      den_s[0] <= d;
      quo_s[0] <= '0;
      clp_s[0] <= 1'b0;
    end
  end

  // First cell decides the clamp and the integer bit.
  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[1] <= neg_s[0];
      den_s[1] <= den_s[0];
      clp_s[1] <= (den_s[0] == '0) || (rem_s[0] > den_s[0]);
      if (rem_s[0] >= den_s[0]) begin
        quo_s[1] <= 64'd1;
        rem_s[1] <= rem_s[0] - den_s[0];
      end else begin
        quo_s[1] <= '0;
        rem_s[1] <= rem_s[0];
      end
    end
  end

  for (genvar k = 1; k < 61; k++) begin : g_cell
    logic [127:0] sh;
    assign sh = rem_s[k] << 1;
    always_ff @(posedge clk) begin
      if (en) begin
        neg_s[k+1] <= neg_s[k];
        den_s[k+1] <= den_s[k];
        clp_s[k+1] <= clp_s[k];
        if (sh >= den_s[k]) begin
          quo_s[k+1] <= {quo_s[k][62:0], 1'b1};
          rem_s[k+1] <= sh - den_s[k];
        end else begin
          quo_s[k+1] <= {quo_s[k][62:0], 1'b0};
          rem_s[k+1] <= sh;
        end
      end
    end
  end

  logic [63:0] mag;
  assign mag = clp_s[61] ? ONE_Q60 : quo_s[61];

  always_ff @(posedge clk) begin
    if (en) begin
      ratio   <= neg_s[61] ? (64'd0 - mag) : mag;
      clamped <= clp_s[61];
    end
  end
endmodule
`default_nettype wire

// File: hdl/sik_atan2.sv
// Vectoring CORDIC atan2 in Q.56: quadrant fold, normalization and 57 rotation cells.
`timescale 1ns / 1ps
`default_nettype none
module sik_atan2 (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  output logic      [63:0] angle
);
  import sik_pkg::*;

  // Normalizer stages: 0 fold, 1..3 coarse right, 4 final right, 5..10 left.
  logic [63:0] nx [11];
  logic [63:0] ny [11];
  logic [63:0] nz [11];

  always_ff @(posedge clk) begin
    if (en) begin
      if (x[63]) begin
        nz[0] <= y[63] ? (64'd0 - PI_Q) : PI_Q;
        nx[0] <= 64'd0 - x;
        ny[0] <= 64'd0 - y;
      end else begin
        nz[0] <= '0;
        nx[0] <= x;
        ny[0] <= y;
      end
    end
  end

  // Find the largest right shift that still leaves the magnitude above bound.
  for (genvar j = 0; j < 3; j++) begin : g_right
    localparam int SH = 4 >> j;
    logic [63:0] xs, ys, ms;
    assign xs = $unsigned($signed(nx[j]) >>> SH);
    assign ys = $unsigned($signed(ny[j]) >>> SH);
    assign ms = (xs > mag64(ys)) ? xs : mag64(ys);
    always_ff @(posedge clk) begin
      if (en) begin
        nz[j+1] <= nz[j];
        if (ms >= NORM_HIGH) begin
          nx[j+1] <= xs;
          ny[j+1] <= ys;
        end else begin
          nx[j+1] <= nx[j];
          ny[j+1] <= ny[j];
        end
      end
    end
  end

  logic [63:0] m3;
  assign m3 = (nx[3] > mag64(ny[3])) ? nx[3] : mag64(ny[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      nz[4] <= nz[3];
      if (m3 >= NORM_HIGH) begin
        nx[4] <= $unsigned($signed(nx[3]) >>> 1);
        ny[4] <= $unsigned($signed(ny[3]) >>> 1);
      end else begin
        nx[4] <= nx[3];
        ny[4] <= ny[3];
      end
    end
  end

  // Each left stage shifts only while the result stays below the upper bound,
  // which leaves the magnitude in [2^58, 2^59).
  for (genvar j = 0; j < 6; j++) begin : g_left
    localparam int SH = 32 >> j;
    logic [63:0] ml;
    assign ml = (nx[j+4] > mag64(ny[j+4])) ? nx[j+4] : mag64(ny[j+4]);
    always_ff @(posedge clk) begin
      if (en) begin
        nz[j+5] <= nz[j+4];
        if (ml < (64'd1 << (59 - SH))) begin
          nx[j+5] <= nx[j+4] << SH;
          ny[j+5] <= ny[j+4] << SH;
        end else begin
          nx[j+5] <= nx[j+4];
          ny[j+5] <= ny[j+4];
        end
      end
    end
  end

  logic [63:0] cx [CORDIC_STEPS+1];
  logic [63:0] cy [CORDIC_STEPS+1];
  logic [63:0] cz [CORDIC_STEPS+1];

  assign cx[0] = nx[10];
  assign cy[0] = ny[10];
  assign cz[0] = nz[10];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    localparam logic [63:0] ATAN = atan_entry(i);
    logic [63:0] xs, ys;
    assign xs = $unsigned($signed(cx[i]) >>> i);
    assign ys = $unsigned($signed(cy[i]) >>> i);
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][63]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + ATAN;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - ATAN;
        end
      end
    end
  end

  assign angle = cz[CORDIC_STEPS];
endmodule
`default_nettype wire

// File: hdl/scara_inverse_kinematics.sv
// Top level of the two-link arm inverse kinematics solver.
`timescale 1ns / 1ps
`default_nettype none
// Two-link (SCARA) inverse kinematics. Each target word (x_pos, y_pos, signed
// Q15.16 mm) yields one result word: the shoulder angle atan2(y,x) plus
// acos((a^2+r^2-b^2)/(2ar)) and the elbow angle acos((r^2-a^2-b^2)/(2ab)),
// in radians as signed Q3.(ANGLE_WIDTH-4) and unsigned Q2.(ANGLE_WIDTH-4)
// respectively, rounded half up. The link lengths a and b are APB
// registers at byte addresses 0 and 4; write them only while the solver
// holds no words in flight. The datapath is a fully pipelined row of
// cells: 64 square-root cells for r, 61 restoring divider cells per cosine
// ratio, 64 square-root cells for sqrt(1-c^2), and three 68-stage CORDIC
// vectoring units (fold, ten normalizer stages, 57 rotations). A new word
// is taken every cycle while the output skid is empty. A ratio outside
// [-1,1] is clamped and reported as CLAMPED; a target at the origin gives
// shoulder 0 and ORIGIN status, which takes priority. A two-entry output
// stage (result register plus skid) lets the solver keep taking words
// while a result waits; the pipeline only halts when both are full.
module scara_inverse_kinematics #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sik_target_if.sink       target,
  sik_joint_if.source      joints,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import sik_pkg::*;

  localparam int RND_SHIFT = 60 - ANGLE_WIDTH;
  localparam int OUT_W = 2 * ANGLE_WIDTH;

  // Configuration registers.
  logic [LINK_WIDTH-1:0] inner_link;
  logic [LINK_WIDTH-1:0] outer_link;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_link <= LINK_WIDTH'(13107200);
      outer_link <= LINK_WIDTH'(13107200);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_INNER: inner_link <= pwdata[LINK_WIDTH-1:0];
        REG_OUTER: outer_link <= pwdata[LINK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_INNER: prdata = {1'b0, inner_link};
      REG_OUTER: prdata = {1'b0, outer_link};
      default:   prdata = '0;
    endcase
  end

  // The whole row advances together; it halts only while the skid is full.
  logic skid_valid;
  logic en;
  logic accept;

  assign en = !skid_valid;
  assign target.ready = en;
  assign accept = target.valid && en;

  // Input register, coordinates widened to 64 bits.
  logic [63:0] xe, ye;
  logic        origin;

  always_ff @(posedge clk) begin
    if (en) begin
      xe     <= 64'($signed(target.x_pos[COORD_WIDTH-1:0]));
      ye     <= 64'($signed(target.y_pos[COORD_WIDTH-1:0]));
      origin <= (target.x_pos == '0) && (target.y_pos == '0);
    end
  end

  logic [63:0] a_ext, b_ext, a2_ext;
  assign a_ext  = {33'd0, inner_link};
  assign b_ext  = {33'd0, outer_link};
  assign a2_ext = {32'd0, inner_link, 1'b0};

  // Squares and the law-of-cosines products.
  logic [127:0] x2, y2, aa, bb, ab2;

  sik_mul u_mul_x (.clk, .en, .a(mag64(xe)), .b(mag64(xe)), .p(x2));
  sik_mul u_mul_y (.clk, .en, .a(mag64(ye)), .b(mag64(ye)), .p(y2));
  sik_mul u_mul_a (.clk, .en, .a(a_ext), .b(a_ext), .p(aa));
  sik_mul u_mul_b (.clk, .en, .a(b_ext), .b(b_ext), .p(bb));
  sik_mul u_mul_ab (.clk, .en, .a(a2_ext), .b(b_ext), .p(ab2));

  logic [127:0] r2, sum_ab, p_sh, bb_q, ab2_q;

  always_ff @(posedge clk) begin
    if (en) begin
      r2     <= x2 + y2;
      sum_ab <= aa + bb;
      p_sh   <= aa + x2 + y2;
      bb_q   <= bb;
      ab2_q  <= ab2;
    end
  end

  // Radius, then 2ar.
  logic [63:0]  r;
  logic [127:0] ar2;

  sik_isqrt u_sqrt_r (.clk, .en, .n(r2), .root(r));
  sik_mul u_mul_ar (.clk, .en, .a(a2_ext), .b(r), .p(ar2));

  logic [639:0] terms_d;
  logic [127:0] r2_d, sum_ab_d, p_sh_d, bb_d, ab2_d;

  sik_delay #(.WIDTH(640), .DEPTH(66)) u_dly_terms (
    .clk, .rst, .en,
    .din({r2, sum_ab, p_sh, bb_q, ab2_q}),
    .dout(terms_d)
  );
  assign {r2_d, sum_ab_d, p_sh_d, bb_d, ab2_d} = terms_d;

  // Cosine ratios for elbow and shoulder.
  logic [63:0] c_el, c_sh;
  logic        clp_el, clp_sh;

  sik_divide u_div_el (
    .clk, .en, .p(r2_d), .q(sum_ab_d), .d(ab2_d), .ratio(c_el), .clamped(clp_el)
  );
  sik_divide u_div_sh (
    .clk, .en, .p(p_sh_d), .q(bb_d), .d(ar2), .ratio(c_sh), .clamped(clp_sh)
  );

  // acos(c) = atan2(sqrt(1 - c^2), c).
  logic [127:0] csq_el, csq_sh, one_el, one_sh;
  logic [63:0]  s_el, s_sh;

  sik_mul u_mul_cel (.clk, .en, .a(mag64(c_el)), .b(mag64(c_el)), .p(csq_el));
  sik_mul u_mul_csh (.clk, .en, .a(mag64(c_sh)), .b(mag64(c_sh)), .p(csq_sh));

  always_ff @(posedge clk) begin
    if (en) begin
      one_el <= ONE_Q120 - csq_el;
      one_sh <= ONE_Q120 - csq_sh;
    end
  end

  sik_isqrt u_sqrt_el (.clk, .en, .n(one_el), .root(s_el));
  sik_isqrt u_sqrt_sh (.clk, .en, .n(one_sh), .root(s_sh));

  logic [63:0] c_el_d, c_sh_d;

  sik_delay #(.WIDTH(128), .DEPTH(67)) u_dly_c (
    .clk, .rst, .en, .din({c_el, c_sh}), .dout({c_el_d, c_sh_d})
  );

  logic [63:0] ang_el, ang_sh, ang_xy, ang_xy_d;

  sik_atan2 u_acos_el (.clk, .en, .x(c_el_d), .y(s_el), .angle(ang_el));
  sik_atan2 u_acos_sh (.clk, .en, .x(c_sh_d), .y(s_sh), .angle(ang_sh));
  sik_atan2 u_atan_xy (.clk, .en, .x(xe), .y(ye), .angle(ang_xy));

  sik_delay #(.WIDTH(64), .DEPTH(199)) u_dly_xy (
    .clk, .rst, .en, .din(ang_xy), .dout(ang_xy_d)
  );

  logic origin_d;
  logic [1:0] clp_d;

  sik_delay #(.WIDTH(1), .DEPTH(267)) u_dly_org (
    .clk, .rst, .en, .din(origin), .dout(origin_d)
  );
  sik_delay #(.WIDTH(2), .DEPTH(135)) u_dly_clp (
    .clk, .rst, .en, .din({clp_el, clp_sh}), .dout(clp_d)
  );

  logic last_valid;

  sik_delay #(.WIDTH(1), .DEPTH(269)) u_dly_vld (
    .clk, .rst, .en, .din(accept), .dout(last_valid)
  );

  // Final combine: shoulder sum, elbow held within 0..pi, status.
  logic [63:0] sh_q, el_q;
  reach_t      st_q;

  always_ff @(posedge clk) begin
    if (en) begin
      sh_q <= origin_d ? 64'd0 : (ang_xy_d + ang_sh);
      if (ang_el[63]) el_q <= '0;
      else if (ang_el > PI_Q) el_q <= PI_Q;
      else el_q <= ang_el;
      if (origin_d) st_q <= ST_ORIGIN;
      else if (clp_d != 2'b00) st_q <= ST_CLAMPED;
      else st_q <= ST_OK;
    end
  end

  logic [63:0] sh_rnd, el_rnd;
  assign sh_rnd = $unsigned($signed(sh_q + (64'd1 << (RND_SHIFT - 1))) >>> RND_SHIFT);
  assign el_rnd = $unsigned($signed(el_q + (64'd1 << (RND_SHIFT - 1))) >>> RND_SHIFT);

  logic [OUT_W-1:0] res_word;
  assign res_word = {sh_rnd[ANGLE_WIDTH-1:0], el_rnd[ANGLE_WIDTH-3:0], st_q};

  // Result register with a one-word skid behind it.
  logic [OUT_W-1:0] out_q, skid_q;
  logic             out_valid;
  logic             push;

  assign push = last_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !joints.ready) begin
      if (push) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !joints.ready) begin
      if (push) skid_q <= res_word;
    end else if (skid_valid) begin
      out_q <= skid_q;
    end else if (push) begin
      out_q <= res_word;
    end
  end

  assign joints.valid = out_valid;
  assign {joints.shoulder_angle, joints.elbow_angle, joints.reach_status} = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the result register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !joints.ready))
    else $error("skid filled without a stalled result");

  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && joints.reach_status == ST_ORIGIN) |-> joints.shoulder_angle == '0)
    else $error("origin target with nonzero shoulder angle");
`endif
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the two-link arm solver: directed and random targets.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import sik_pkg::*;

  // Settling wait after the last result; it exceeds the solver's pipeline depth.
  localparam int LATENCY_WAIT = 320;
  // Slowest correct run is well below this even with heavy stalls.
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] ONE60 = 64'd1 << 60;
  localparam logic [30:0] LINK_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] shoulder;
    logic [29:0] elbow;
    reach_t status;
  } joint_word_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    bit typed;
    joint_word_t want;
  } target_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  sik_target_if #(.COORD_WIDTH(32)) tgt ();
  sik_joint_if #(.ANGLE_WIDTH(32)) jnt ();

  scara_inverse_kinematics #(.COORD_WIDTH(32), .ANGLE_WIDTH(32)) dut (
    .clk(clk), .rst(rst), .target(tgt), .joints(jnt),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Bench copies of the link registers and of the angle constants.
  logic [30:0] inner_len;
  logic [30:0] outer_len;
  logic [63:0] atan_tbl [CORDIC_STEPS];
  logic [63:0] pi_val;

  joint_word_t pending_joints[$];
  int mismatches;
  int cycles;
  int idle_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gregory series for atan(1/n) in Q.62, stopping when the term vanishes.
  function automatic logic [63:0] gregory(input logic [63:0] n);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] d;
    logic [63:0] k;
    sum = '0;
    term = (64'd1 << 62) / n;
    k = '0;
    while (term != 0) begin
      d = term / (2 * k + 1);
      if (k[0]) sum = sum - d;
      else sum = sum + d;
      term = term / n / n;
      k = k + 1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] v, input int s);
    return 64'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] magn(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] root128(input logic [127:0] n);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 63; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) res = c;
    end
    return res;
  endfunction

  // CORDIC vectoring angle in Q.56; x and y are never both zero here.
  function automatic logic [63:0] heading(input logic [63:0] xi, input logic [63:0] yi);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] m;
    logic [63:0] xs;
    logic [63:0] ys;
    x = xi;
    y = yi;
    z = '0;
    if (x[63]) begin
      z = y[63] ? (64'd0 - pi_val) : pi_val;
      x = 64'd0 - x;
      y = 64'd0 - y;
    end
    m = (x > magn(y)) ? x : magn(y);
    while (m >= (64'd1 << 59)) begin
      x = asr(x, 1);
      y = asr(y, 1);
      m = (x > magn(y)) ? x : magn(y);
    end
    while (m < (64'd1 << 58)) begin
      x = x << 1;
      y = y << 1;
      m = m << 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = asr(x, i);
      ys = asr(y, i);
      if (!y[63]) begin
        x = x + ys; y = y - xs; z = z + atan_tbl[i];
      end else begin
        x = x - ys; y = y + xs; z = z - atan_tbl[i];
      end
    end
    return z;
  endfunction

  // (p - q) / d in signed Q.60, clamped to plus or minus one.
  function automatic logic [63:0] cos_ratio(input logic [127:0] p, input logic [127:0] q,
                                            input logic [127:0] d, inout bit clamped);
    bit neg;
    logic [127:0] rem;
    logic [63:0] quo;
    neg = p < q;
    rem = neg ? (q - p) : (p - q);
    quo = '0;
    if (d == 0 || rem > d) begin
      clamped = 1'b1;
      quo = ONE60;
    end else begin
      if (rem >= d) begin
        quo = 64'd1;
        rem = rem - d;
      end
      for (int i = 0; i < 60; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= d) begin
          quo[0] = 1'b1;
          rem = rem - d;
        end
      end
    end
    return neg ? (64'd0 - quo) : quo;
  endfunction

  function automatic logic [63:0] arccos(input logic [63:0] c);
    logic [63:0] m;
    m = magn(c);
    return heading(c, root128((128'd1 << 120) - {64'd0, m} * {64'd0, m}));
  endfunction

  function automatic logic [63:0] to_q28(input logic [63:0] v);
    return asr(v + (64'd1 << 27), 28);
  endfunction

  // Joint angles for one target under the current link lengths.
  function automatic joint_word_t solve_joints(input logic signed [31:0] xp,
                                               input logic signed [31:0] yp);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] r;
    logic [63:0] elbow;
    logic [63:0] shoulder;
    logic [127:0] r2;
    logic [127:0] a2;
    logic [127:0] b2;
    bit clamped;
    joint_word_t w;
    x = 64'(xp);
    y = 64'(yp);
    a = {33'd0, inner_len};
    b = {33'd0, outer_len};
    clamped = 1'b0;
    r2 = {64'd0, magn(x)} * {64'd0, magn(x)} + {64'd0, magn(y)} * {64'd0, magn(y)};
    r = root128(r2);
    a2 = {64'd0, a} * {64'd0, a};
    b2 = {64'd0, b} * {64'd0, b};
    elbow = arccos(cos_ratio(r2, a2 + b2, {64'd0, 2 * a} * {64'd0, b}, clamped));
    if (elbow[63]) elbow = '0;
    else if (elbow > pi_val) elbow = pi_val;
    if (x == 0 && y == 0) begin
      shoulder = '0;
      w.status = ST_ORIGIN;
    end else begin
      shoulder = heading(x, y) +
                 arccos(cos_ratio(a2 + r2, b2, {64'd0, 2 * a} * {64'd0, r}, clamped));
      w.status = clamped ? ST_CLAMPED : ST_OK;
    end
    w.shoulder = 32'(to_q28(shoulder));
    w.elbow = 30'(to_q28(elbow));
    return w;
  endfunction

  // One APB write: setup cycle, then access cycle.
  task automatic write_link(input logic idx, input logic [30:0] len);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (idx == REG_INNER) ? 3'd0 : 3'd4;
    pwdata <= {1'b0, len};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_INNER) inner_len = len;
    else outer_len = len;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offers one target word; called and returning at a falling edge.
  task automatic send_target(input logic signed [31:0] x, input logic signed [31:0] y,
                             input bit typed, input joint_word_t want);
    while ($urandom_range(99) < idle_pct) begin
      tgt.valid <= 1'b0;
      @(negedge clk);
    end
    tgt.valid <= 1'b1;
    tgt.x_pos <= x;
    tgt.y_pos <= y;
    @(posedge clk);
    while (!tgt.ready) @(posedge clk);
    pending_joints.push_back(typed ? want : solve_joints(x, y));
    @(negedge clk);
  endtask

  // Waits until every result is in, then for the pipeline to settle.
  task automatic drain();
    tgt.valid <= 1'b0;
    while (pending_joints.size() != 0) @(negedge clk);
    repeat (LATENCY_WAIT) @(negedge clk);
  endtask

  // Random coordinate, mostly within reach of the current links.
  function automatic logic signed [31:0] pick_coord();
    logic [63:0] reach;
    logic [63:0] v;
    int kind;
    kind = $urandom_range(99);
    reach = {33'd0, inner_len} + {33'd0, outer_len};
    if (kind < 60) begin
      v = {$urandom, $urandom} % (reach + 1);
      if (v > 64'h7FFF_FFFF) v = 64'h7FFF_FFFF;
      return $urandom_range(1) ? -$signed(v[31:0]) : $signed(v[31:0]);
    end else if (kind < 80) begin
      return $signed($urandom);
    end else if (kind < 90) begin
      return $signed(32'($urandom_range(255)) - 32'd128);
    end
    return 32'sd0;
  endfunction

  // Receiver ready toggles at random on the falling edge.
  always @(negedge clk) begin
    jnt.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checking against the oldest pending word.
  always @(posedge clk) begin
    joint_word_t got;
    joint_word_t want;
    if (!rst && jnt.valid && jnt.ready) begin
      got.shoulder = jnt.shoulder_angle;
      got.elbow = jnt.elbow_angle;
      got.status = reach_t'(jnt.reach_status);
      if (pending_joints.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_joints.pop_front();
        if (got.shoulder !== want.shoulder || got.elbow !== want.elbow ||
            got.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: shoulder %h/%h elbow %h/%h status %0d/%0d (exp/got)",
                     want.shoulder, got.shoulder, want.elbow, got.elbow,
                     want.status, got.status);
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("scara_inverse_kinematics test failed");
      $finish;
    end
  end

  initial begin
    target_row_t rows[$];
    target_row_t row;
    joint_word_t none;
    logic [30:0] links [8][2];
    logic [63:0] p62;

    cycles = 0;
    mismatches = 0;
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tgt.valid = 1'b0;
    tgt.x_pos = '0;
    tgt.y_pos = '0;
    jnt.ready = 1'b1;
    none = '0;
    inner_len = 31'd13107200;
    outer_len = 31'd13107200;

    // Pi from Machin's formula, the other table entries from the Gregory series, Q.62 rounded to Q.56.
    p62 = 16 * gregory(64'd5) - 4 * gregory(64'd239);
    pi_val = (p62 + 64'd32) >> 6;
    atan_tbl[0] = ((p62 / 4) + 64'd32) >> 6;
    for (int i = 1; i < CORDIC_STEPS; i++)
      atan_tbl[i] = (gregory(64'd1 << i) + 64'd32) >> 6;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed targets under the reset link lengths (200 mm each). The
    // origin row is typed in: shoulder zero, elbow pi, origin status.
    row.typed = 1'b1;
    row.want.shoulder = '0;
    row.want.elbow = 30'd843314857;
    row.want.status = ST_ORIGIN;
    row.x = 0; row.y = 0;
    rows.push_back(row);
    row.typed = 1'b0;
    row.want = none;
    row.x = 32'sd26214400; row.y = 0; rows.push_back(row);          // full reach
    row.x = 32'sd26214401; row.y = 0; rows.push_back(row);          // just past it
    row.x = -32'sd26214400; row.y = 0; rows.push_back(row);
    row.x = 0; row.y = 32'sd13107200; rows.push_back(row);
    row.x = 0; row.y = -32'sd13107200; rows.push_back(row);
    row.x = -32'sd9000000; row.y = -32'sd9000000; rows.push_back(row);
    row.x = -32'sd9000000; row.y = 32'sd9000000; rows.push_back(row);
    row.x = 32'sd1; row.y = 0; rows.push_back(row);
    row.x = 0; row.y = -32'sd1; rows.push_back(row);
    row.x = -32'sd1; row.y = 0; rows.push_back(row);
    row.x = 32'h7FFF_FFFF; row.y = 32'h7FFF_FFFF; rows.push_back(row);
    row.x = 32'h8000_0000; row.y = 32'h8000_0000; rows.push_back(row);
    row.x = 32'h7FFF_FFFF; row.y = 32'h8000_0000; rows.push_back(row);
    row.x = 32'h8000_0000; row.y = 0; rows.push_back(row);
    row.x = 32'sd100; row.y = 32'sd100; rows.push_back(row);
    row.x = 32'sd18000000; row.y = 32'sd5000000; rows.push_back(row);
    foreach (rows[i]) send_target(rows[i].x, rows[i].y, rows[i].typed, rows[i].want);
    drain();

    // Link settings per phase, extremes among them.
    links[0] = '{31'd1, 31'd1};
    links[1] = '{LINK_MAX, LINK_MAX};
    links[2] = '{LINK_MAX, 31'd1};
    links[3] = '{31'd1, LINK_MAX};
    links[4] = '{31'd13107200, 31'd6553600};
    links[5] = '{31'd3276800, 31'd9830400};
    links[6] = '{31'($urandom), 31'($urandom)};
    links[7] = '{31'd13107200, 31'd13107200};

    for (int p = 0; p < 8; p++) begin
      write_link(REG_INNER, links[p][0]);
      write_link(REG_OUTER, links[p][1]);
      // Idle pattern cycles through: none, sender idle, receiver stall, both.
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 80; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 80; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      for (int n = 0; n < 80; n++) begin
        // In one phase, hold the sender until the solver has emptied.
        if (p == 4 && n == 40) begin
          tgt.valid <= 1'b0;
          while (pending_joints.size() != 0) @(negedge clk);
        end
        send_target(pick_coord(), pick_coord(), 1'b0, none);
      end
      drain();
    end
    stall_pct = 0;

    if (mismatches == 0 && pending_joints.size() == 0) begin
      $display("scara_inverse_kinematics test passed");
    end else begin
      $display("scara_inverse_kinematics test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
